[rtl/lhr_pkg.sv]
// Shared types, codes and constants of the line history ring.
// Used by lhr_ctrl, lhr_datapath and line_history_ring; depends on nothing.
package lhr_pkg;

  // Default ring size in bytes and the longest line that can be stored.
  localparam int unsigned RING_LEN_DEF = 64;
  localparam int unsigned MAX_LINE     = 62;
  localparam int unsigned LEN_W        = 6;

  // Request action codes.
  localparam logic [1:0] ACT_SAVE  = 2'd0;
  localparam logic [1:0] ACT_OLDER = 2'd1;
  localparam logic [1:0] ACT_NEWER = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  // Read address selection for the ring store.
  localparam logic [1:0] RD_HOP    = 2'd0;
  localparam logic [1:0] RD_OLDEST = 2'd1;
  localparam logic [1:0] RD_EMIT   = 2'd2;

  // One request.
  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       char_byte;
    logic [LEN_W-1:0] line_length;
    logic             last;
  } req_t;

  // One result.
  typedef struct packed {
    logic [7:0]       out_byte;
    logic [1:0]       status;
    logic [LEN_W-1:0] out_length;
    logic             end_of_run;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_req;
    logic       save_begin;
    logic       evict_step;
    logic       char_write;
    logic       commit_hdr;
    logic       commit_term;
    logic       finalize;
    logic       rec_decide;
    logic       seek_step;
    logic       emit_setup;
    logic       emit_rd;
    logic [1:0] rd_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_action;
    logic       req_last;
    logic       evict_req;
    logic       room_ok;
    logic       commit_ok;
    logic       rec_go;
    logic       seek_hit;
    logic       emit_last;
  } sts_t;

endpackage

[rtl/lhr_ctrl.sv]
// Controller state machine of the line history ring.
// Depends on lhr_pkg; drives the command struct of lhr_datapath.
module lhr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lhr_pkg::sts_t sts_i,
  output lhr_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import lhr_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SV_BEGIN = 4'd2;
  localparam logic [3:0] S_EV_RD    = 4'd3;
  localparam logic [3:0] S_EV_CHK   = 4'd4;
  localparam logic [3:0] S_SV_WRITE = 4'd5;
  localparam logic [3:0] S_COMMIT   = 4'd6;
  localparam logic [3:0] S_TERM     = 4'd7;
  localparam logic [3:0] S_SK_RD    = 4'd8;
  localparam logic [3:0] S_SK_CHK   = 4'd9;
  localparam logic [3:0] S_EM       = 4'd10;
  localparam logic [3:0] S_EM_WAIT  = 4'd11;

  logic [3:0] state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_HOP;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch_req = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.req_action)
          ACT_SAVE: begin
            state_d = S_SV_BEGIN;
          end
          ACT_OLDER, ACT_NEWER: begin
            cmd_o.rec_decide = 1'b1;
            state_d = sts_i.rec_go ? S_SK_RD : S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SV_BEGIN: begin
        cmd_o.save_begin = 1'b1;
        state_d = sts_i.evict_req ? S_EV_RD : S_SV_WRITE;
      end
      S_EV_RD: begin
        cmd_o.rd_sel = RD_OLDEST;
        state_d = S_EV_CHK;
      end
      S_EV_CHK: begin
        if (sts_i.room_ok) begin
          state_d = S_SV_WRITE;
        end else begin
          cmd_o.evict_step = 1'b1;
          state_d = S_EV_RD;
        end
      end
      S_SV_WRITE: begin
        cmd_o.char_write = 1'b1;
        state_d = sts_i.req_last ? S_COMMIT : S_IDLE;
      end
      S_COMMIT: begin
        if (sts_i.commit_ok) begin
          cmd_o.commit_hdr = 1'b1;
          state_d = S_TERM;
        end else begin
          cmd_o.finalize = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TERM: begin
        cmd_o.commit_term = 1'b1;
        cmd_o.finalize    = 1'b1;
        state_d = S_IDLE;
      end
      S_SK_RD: begin
        state_d = S_SK_CHK;
      end
      S_SK_CHK: begin
        if (sts_i.seek_hit) begin
          cmd_o.emit_setup = 1'b1;
          state_d = S_EM;
        end else begin
          cmd_o.seek_step = 1'b1;
          state_d = S_SK_RD;
        end
      end
      S_EM: begin
        cmd_o.rd_sel  = RD_EMIT;
        cmd_o.emit_rd = 1'b1;
        if (sts_i.emit_last) begin
          state_d = S_EM_WAIT;
        end
      end
      S_EM_WAIT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[rtl/lhr_datapath.sv]
// Datapath of the line history ring: ring store, pointers and result register.
// Depends on lhr_pkg; obeys the command struct from lhr_ctrl.
module lhr_datapath #(
  parameter int unsigned RING_LEN = lhr_pkg::RING_LEN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lhr_pkg::req_t req_i,
  input  lhr_pkg::cmd_t cmd_i,
  output lhr_pkg::sts_t sts_o,
  output lhr_pkg::res_t res_o,
  output logic          res_strobe_o
);
  import lhr_pkg::*;

  localparam int unsigned PTR_W = $clog2(RING_LEN);
  localparam int unsigned SW    = ((PTR_W > 8) ? PTR_W : 8) + 1;
  localparam int unsigned CW    = ((PTR_W + 1) > (LEN_W + 1)) ? (PTR_W + 1) : (LEN_W + 1);

  // Step from a header to the next one; the sum stays below twice the ring length.
  function automatic logic [PTR_W-1:0] hop(input logic [PTR_W-1:0] pos,
                                           input logic [7:0] step);
    logic [SW-1:0] sum;
    sum = SW'(pos) + SW'(step) + SW'(1);
    if (sum >= SW'(RING_LEN)) begin
      sum = sum - SW'(RING_LEN);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Advance one position with wrap-around.
  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] pos);
    return (pos == PTR_W'(RING_LEN - 1)) ? '0 : pos + PTR_W'(1);
  endfunction

  // Ring store with a valid bit per entry; an entry never written reads as zero.
  logic [7:0]          mem_q [RING_LEN];
  logic [RING_LEN-1:0] vld_q;
  logic [7:0]          rd_byte_q;
  logic                rd_vld_q;
  logic [7:0]          rd_data;
  logic [PTR_W-1:0]    rd_addr, wr_addr;
  logic [7:0]          wr_data;
  logic                wr_en;

  // Committed list and save state.
  req_t             req_q;
  logic [PTR_W-1:0] oldest_q, tail_q, bi_q, wpos_q, cnt_q;
  logic             sv_busy_q, sv_drop_q;
  logic [LEN_W-1:0] sv_len_q, sv_cnt_q;

  // Walk and emission state.
  logic [PTR_W-1:0] hpos_q, hidx_q, target_q, epos_q;
  logic [LEN_W-1:0] elen_q, ecnt_q;
  logic             pend_q, pend_last_q;
  res_t             res_q;
  logic             res_vld_q;

  logic             drop_now, char_ok, older_go, newer_go, rec_go;
  logic [PTR_W-1:0] bi_dec;
  logic [CW-1:0]    free_sp;

  assign rd_data = rd_vld_q ? rd_byte_q : 8'h00;

  // Decisions taken from the latched request and the registers.
  always_comb begin
    drop_now = (CW'(req_q.line_length) > CW'(RING_LEN - 2)) ||
               (req_q.line_length > LEN_W'(MAX_LINE));
    char_ok  = !sv_drop_q && (sv_cnt_q < sv_len_q);
    if (tail_q >= oldest_q) begin
      free_sp = CW'(RING_LEN) - CW'(tail_q) + CW'(oldest_q) - CW'(1);
    end else begin
      free_sp = CW'(oldest_q) - CW'(tail_q) - CW'(1);
    end
    bi_dec   = bi_q - PTR_W'(1);
    older_go = (bi_q < cnt_q);
    newer_go = (bi_q != '0) && (bi_dec != '0) && (bi_dec <= cnt_q);
    case (req_q.action)
      ACT_OLDER: rec_go = older_go;
      ACT_NEWER: rec_go = newer_go;
      default:   rec_go = 1'b0;
    endcase
  end

  assign sts_o.req_action = req_q.action;
  assign sts_o.req_last   = req_q.last;
  assign sts_o.evict_req  = !sv_busy_q && !drop_now && (req_q.line_length != '0);
  assign sts_o.room_ok    = (rd_data == 8'h00) || (free_sp > CW'(sv_len_q));
  assign sts_o.commit_ok  = !sv_drop_q && (sv_cnt_q != '0);
  assign sts_o.rec_go     = rec_go;
  assign sts_o.seek_hit   = (hidx_q == target_q);
  assign sts_o.emit_last  = (ecnt_q == elen_q - LEN_W'(1));

  // Store port selection.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_OLDEST: rd_addr = oldest_q;
      RD_EMIT:   rd_addr = epos_q;
      default:   rd_addr = hpos_q;
    endcase
    wr_en   = (cmd_i.char_write && char_ok) || cmd_i.commit_hdr || cmd_i.commit_term;
    wr_addr = cmd_i.char_write ? wpos_q : tail_q;
    if (cmd_i.char_write) begin
      wr_data = req_q.char_byte;
    end else if (cmd_i.commit_hdr) begin
      wr_data = 8'(sv_cnt_q);
    end else begin
      wr_data = 8'h00;
    end
  end

  // Store array and its registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_byte_q <= mem_q[rd_addr];
  end

  // Valid bits, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  // List pointers, save state and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      tail_q      <= '0;
      bi_q        <= '0;
      wpos_q      <= '0;
      cnt_q       <= '0;
      sv_busy_q   <= 1'b0;
      sv_drop_q   <= 1'b0;
      sv_len_q    <= '0;
      sv_cnt_q    <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      // Open a save on the first character of a line.
      if (cmd_i.save_begin && !sv_busy_q) begin
        sv_busy_q <= 1'b1;
        sv_drop_q <= drop_now;
        sv_len_q  <= req_q.line_length;
        sv_cnt_q  <= '0;
        wpos_q    <= inc(tail_q);
      end
      // Drop the oldest record to make room.
      if (cmd_i.evict_step) begin
        oldest_q <= hop(oldest_q, rd_data);
        cnt_q    <= cnt_q - PTR_W'(1);
      end
      // Store one character after the tail.
      if (cmd_i.char_write && char_ok) begin
        wpos_q   <= inc(wpos_q);
        sv_cnt_q <= sv_cnt_q + LEN_W'(1);
      end
      // Header written: the tail moves past the new record.
      if (cmd_i.commit_hdr) begin
        tail_q <= hop(tail_q, 8'(sv_cnt_q));
        cnt_q  <= cnt_q + PTR_W'(1);
      end
      // Close the save.
      if (cmd_i.finalize) begin
        if (!sv_drop_q) begin
          bi_q <= '0;
        end
        sv_busy_q <= 1'b0;
        sv_drop_q <= 1'b0;
        sv_len_q  <= '0;
        sv_cnt_q  <= '0;
        wpos_q    <= inc(tail_q);
      end
      // Browse index moves on a recall.
      if (cmd_i.rec_decide) begin
        if (req_q.action == ACT_OLDER && older_go) begin
          bi_q <= bi_q + PTR_W'(1);
        end else if (req_q.action == ACT_NEWER && bi_q != '0) begin
          bi_q <= bi_dec;
        end
      end
      pend_q      <= cmd_i.emit_rd;
      pend_last_q <= cmd_i.emit_rd && sts_o.emit_last;
      res_vld_q   <= pend_q || (cmd_i.rec_decide && !rec_go);
    end
  end

  // Request latch, walk registers and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q <= req_i;
    end
    if (cmd_i.rec_decide) begin
      hpos_q <= oldest_q;
      hidx_q <= '0;
      if (req_q.action == ACT_OLDER) begin
        target_q <= cnt_q - PTR_W'(1) - bi_q;
      end else begin
        target_q <= cnt_q - bi_dec;
      end
    end
    if (cmd_i.seek_step) begin
      hpos_q <= hop(hpos_q, rd_data);
      hidx_q <= hidx_q + PTR_W'(1);
    end
    if (cmd_i.emit_setup) begin
      elen_q <= (rd_data > 8'(MAX_LINE)) ? LEN_W'(MAX_LINE) : rd_data[LEN_W-1:0];
      epos_q <= inc(hpos_q);
      ecnt_q <= '0;
    end
    if (cmd_i.emit_rd) begin
      epos_q <= inc(epos_q);
      ecnt_q <= ecnt_q + LEN_W'(1);
    end
    // Result payload: a recalled character, or a status on a recall miss.
    if (pend_q) begin
      res_q.out_byte   <= rd_data;
      res_q.status     <= ST_BYTE;
      res_q.out_length <= elen_q;
      res_q.end_of_run <= pend_last_q;
    end else if (cmd_i.rec_decide && !rec_go) begin
      res_q.out_byte   <= 8'h00;
      res_q.status     <= (req_q.action == ACT_OLDER) ? ST_NONE : ST_EMPTY;
      res_q.out_length <= '0;
      res_q.end_of_run <= 1'b1;
    end
  end

  assign res_o        = res_q;
  assign res_strobe_o = res_vld_q;

endmodule

[rtl/line_history_ring.sv]
// Top level of the line history ring: command-line history in a byte ring.
// Depends on lhr_pkg, lhr_ctrl and lhr_datapath.
//
//   Channel   Ports                    Handshake
//   request   start, busy, req_i       taken when start is high and busy is low
//   result    res_strobe_o, res_o      valid for the one cycle the strobe is high
//
// A save request passes through dispatch, save begin and the character write. On the
// first character of a line that is kept and not empty, a room check reads the oldest
// header and each record evicted repeats it; the last character adds a commit step,
// and a terminator write when a record is written. A recall walks the headers, each
// hop a registered read of the single store port, then emits one character per cycle;
// a recall that finds no line returns its status from the dispatch step.
// Reset clears the store through per-entry valid bits at once, with no sweep.
// Results cannot be held off; busy stays high until a request is complete.
module line_history_ring #(
  parameter int unsigned RING_LEN = lhr_pkg::RING_LEN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lhr_pkg::req_t req_i,
  output lhr_pkg::res_t res_o,
  output logic          res_strobe_o
);
  import lhr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of each request.
  lhr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // Ring store, pointers and result register.
  lhr_datapath #(
    .RING_LEN(RING_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o),
    .res_strobe_o(res_strobe_o)
  );

endmodule

[sim/line_history_ring_test.sv]
// Self-checking testbench for line_history_ring: saves and recalls command lines
// against a predictor of the byte ring. Depends on lhr_pkg and line_history_ring.
`timescale 1ns / 100ps

module line_history_ring_test;
  import lhr_pkg::*;

  localparam int unsigned RL           = RING_LEN_DEF;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_REQS  = 105;

  // A request waiting to be driven, with the chance of an idle cycle before it.
  typedef struct {
    req_t        req;
    int unsigned idle_pct;
  } pending_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  res_t res_o;
  logic res_strobe_o;

  pending_req_t pending_reqs[$];
  res_t         recall_expect[$];
  logic         accepted_q = 1'b0;
  int unsigned  fail_count = 0;

  // Predicted contents of the history ring.
  logic [7:0]  hist_ring [RL];
  int unsigned oldest_hdr;
  int unsigned tail_hdr;
  int unsigned browse_depth;
  int unsigned char_slot;
  bit          saving;
  bit          dropping;
  int unsigned line_len_q;
  int unsigned char_count;

  line_history_ring u_top (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .res_o,
    .res_strobe_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Header of the record that follows the one at h.
  function automatic int unsigned hop(int unsigned h);
    return (h + hist_ring[h] + 1) % RL;
  endfunction

  function automatic bit fits(int unsigned len);
    if (hist_ring[oldest_hdr] == 8'd0) return 1'b1;
    if (tail_hdr >= oldest_hdr) return (RL - tail_hdr + oldest_hdr - 1) > len;
    return (oldest_hdr - tail_hdr - 1) > len;
  endfunction

  function automatic int unsigned count_lines();
    int unsigned h;
    int unsigned n;
    h = oldest_hdr;
    n = 0;
    for (int g = 0; g < RL && hist_ring[h] != 8'd0; g++) begin
      h = hop(h);
      n++;
    end
    return n;
  endfunction

  // Walks from the oldest record to record number target, or to the terminator.
  function automatic int unsigned find_line(int target);
    int unsigned h;
    int          j;
    h = oldest_hdr;
    j = 0;
    for (int g = 0; g < RL && hist_ring[h] != 8'd0 && j != target; g++) begin
      h = hop(h);
      j++;
    end
    return h;
  endfunction

  function automatic void expect_result(logic [7:0] b, logic [1:0] st, logic [5:0] len,
                                        logic fin);
    res_t r;
    r.out_byte   = b;
    r.status     = st;
    r.out_length = len;
    r.end_of_run = fin;
    recall_expect.push_back(r);
  endfunction

  // Expected bytes of the record at h, or an empty-line status.
  function automatic void expect_line(int unsigned h);
    int unsigned len;
    len = hist_ring[h];
    if (len == 0) begin
      expect_result(8'd0, ST_EMPTY, '0, 1'b1);
      return;
    end
    if (len > MAX_LINE) len = MAX_LINE;
    for (int unsigned k = 0; k < len; k++)
      expect_result(hist_ring[(h + 1 + k) % RL], ST_BYTE, 6'(len), k + 1 == len);
  endfunction

  // One character of a saved line; the first evicts, the last commits.
  function automatic void save_char(logic [7:0] ch, int unsigned len, bit fin);
    if (!saving) begin
      saving     = 1'b1;
      char_count = 0;
      line_len_q = len;
      dropping   = (len > RL - 2) || (len > MAX_LINE);
      char_slot  = (tail_hdr + 1) % RL;
      if (!dropping && len > 0)
        for (int g = 0; g < RL && !fits(len); g++) oldest_hdr = hop(oldest_hdr);
    end
    if (!dropping && char_count < line_len_q) begin
      hist_ring[char_slot] = ch;
      char_slot  = (char_slot + 1) % RL;
      char_count++;
    end
    if (fin) begin
      if (!dropping) begin
        if (char_count > 0) begin
          hist_ring[tail_hdr] = 8'(char_count);
          tail_hdr = (tail_hdr + char_count + 1) % RL;
          hist_ring[tail_hdr] = 8'd0;
        end
        browse_depth = 0;
      end
      saving     = 1'b0;
      dropping   = 1'b0;
      line_len_q = 0;
      char_count = 0;
      char_slot  = (tail_hdr + 1) % RL;
    end
  endfunction

  function automatic void predict_request(req_t r);
    int unsigned cnt;
    int unsigned h;
    cnt = count_lines();
    case (r.action)
      ACT_SAVE: begin
        save_char(r.char_byte, r.line_length, r.last);
      end
      ACT_OLDER: begin
        h = find_line(int'(cnt) - 1 - int'(browse_depth));
        if (cnt >= browse_depth && hist_ring[h] != 8'd0) begin
          browse_depth++;
          expect_line(h);
        end else begin
          expect_result(8'd0, ST_NONE, '0, 1'b1);
        end
      end
      ACT_NEWER: begin
        if (browse_depth > 0) begin
          browse_depth--;
          expect_line(find_line(int'(cnt) - int'(browse_depth)));
        end else begin
          expect_result(8'd0, ST_EMPTY, '0, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void queue_req(logic [1:0] act, logic [7:0] ch, logic [5:0] len,
                                    logic fin);
    pending_req_t p;
    p.req.action      = act;
    p.req.char_byte   = ch;
    p.req.line_length = len;
    p.req.last        = fin;
    p.idle_pct        = 0;
    pending_reqs.push_back(p);
  endfunction

  function automatic void queue_random_recall();
    queue_req($urandom_range(1) ? ACT_OLDER : ACT_NEWER, 8'($urandom_range(255)),
              6'($urandom_range(63)), 1'($urandom_range(1)));
  endfunction

  // A save of steps characters announced as len long, optionally with a recall inside.
  function automatic void queue_line(int unsigned len, int unsigned steps, bit with_recall);
    for (int unsigned s = 0; s < steps; s++) begin
      if (with_recall && s == steps / 2 && s != 0) queue_random_recall();
      queue_req(ACT_SAVE, 8'($urandom_range(255)), 6'(len), s + 1 == steps);
    end
  endfunction

  // Driver: a request is held until taken, then the next one follows or start drops.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else if (!start || accepted_q) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= pending_reqs[0].idle_pct) begin
        req_i <= pending_reqs[0].req;
        start <= 1'b1;
        void'(pending_reqs.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results are checked first, then a request taken at this edge is predicted.
  always @(posedge clk_i) begin : monitor
    res_t want;
    if (!rst_ni) begin
      accepted_q <= 1'b0;
    end else begin
      accepted_q <= start && !busy;
      if (res_strobe_o) begin
        if (recall_expect.size() == 0) begin
          $error("unexpected result %h with no recall outstanding", res_o);
          fail_count++;
        end else begin
          want = recall_expect.pop_front();
          if (res_o.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, res_o.out_byte);
            fail_count++;
          end
          if (res_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_o.status);
            fail_count++;
          end
          if (res_o.out_length !== want.out_length) begin
            $error("out_length: expected %0d, actual %0d", want.out_length, res_o.out_length);
            fail_count++;
          end
          if (res_o.end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %0b, actual %0b", want.end_of_run, res_o.end_of_run);
            fail_count++;
          end
        end
      end
      if (start && !busy) predict_request(req_i);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned target;
    int unsigned n;

    for (int i = 0; i < RL; i++) hist_ring[i] = 8'd0;
    oldest_hdr   = 0;
    tail_hdr     = 0;
    browse_depth = 0;
    char_slot    = 0;
    saving       = 1'b0;
    dropping     = 1'b0;
    line_len_q   = 0;
    char_count   = 0;

    // Recalls on an empty history, and the unused action.
    queue_req(ACT_OLDER, 8'h00, 6'd0, 1'b0);
    queue_req(ACT_NEWER, 8'hFF, 6'h3F, 1'b1);
    queue_req(ACT_UNUSED, 8'hFF, 6'h3F, 1'b1);
    // A zero-length line only clears the browse position.
    queue_req(ACT_SAVE, 8'h00, 6'd0, 1'b1);
    // A short line with extreme characters.
    queue_req(ACT_SAVE, 8'h00, 6'd3, 1'b0);
    queue_req(ACT_SAVE, 8'hFF, 6'd3, 1'b0);
    queue_req(ACT_SAVE, 8'hA5, 6'd3, 1'b1);
    // A line too long for the ring is dropped.
    queue_req(ACT_SAVE, 8'h11, 6'h3F, 1'b0);
    queue_req(ACT_SAVE, 8'h22, 6'h3F, 1'b1);
    // Characters beyond the announced length are ignored.
    queue_req(ACT_SAVE, 8'h31, 6'd1, 1'b0);
    queue_req(ACT_SAVE, 8'h32, 6'd1, 1'b0);
    queue_req(ACT_SAVE, 8'h33, 6'd1, 1'b1);
    // An early last stores only what has arrived.
    queue_req(ACT_SAVE, 8'h41, 6'd5, 1'b0);
    queue_req(ACT_SAVE, 8'h42, 6'd5, 1'b1);
    // A recall in the middle of a save is served from the committed lines.
    queue_req(ACT_SAVE, 8'h5A, 6'd2, 1'b0);
    queue_req(ACT_OLDER, 8'h00, 6'd0, 1'b0);
    queue_req(ACT_SAVE, 8'hC3, 6'd2, 1'b1);
    // Walk to the oldest line and back past the newest.
    repeat (4) queue_req(ACT_OLDER, 8'h00, 6'd0, 1'b0);
    repeat (4) queue_req(ACT_NEWER, 8'h00, 6'd0, 1'b0);

    // Random part: mostly whole lines and runs of recalls, some broken saves and noise.
    target = pending_reqs.size() + RANDOM_REQS;
    while (pending_reqs.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(9) == 0) len = ($urandom_range(3) == 0) ? MAX_LINE
                                                                    : $urandom_range(61, 20);
        else len = $urandom_range(12, 1);
        queue_line(len, len, $urandom_range(7) == 0);
      end else if (pick < 80) begin
        repeat ($urandom_range(4, 1)) queue_random_recall();
      end else if (pick < 86) begin
        len = $urandom_range(20, 2);
        queue_line(len, $urandom_range(len - 1, 1), 1'b0);
      end else if (pick < 90) begin
        len = $urandom_range(6, 1);
        queue_line(len, len + $urandom_range(3, 1), 1'b0);
      end else if (pick < 93) begin
        queue_line(MAX_LINE + 1, $urandom_range(4, 1), 1'b0);
      end else if (pick < 96) begin
        queue_line(0, 1, 1'b0);
      end else begin
        queue_req(ACT_UNUSED, 8'($urandom_range(255)), 6'($urandom_range(63)),
                  1'($urandom_range(1)));
      end
    end

    // Sender idles rarely, then often, then never.
    n = pending_reqs.size();
    for (int unsigned i = 0; i < n; i++)
      pending_reqs[i].idle_pct = (i < n / 3) ? 6 : (i < 2 * n / 3) ? 84 : 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || start || recall_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && recall_expect.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung block.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
